### sv/weighted_vector_distance_assert.svh
// Assertion macros shared by the weighted vector distance RTL
// Depends on nothing; included by the files that carry assertions
`ifndef WEIGHTED_VECTOR_DISTANCE_ASSERT_SVH
`define WEIGHTED_VECTOR_DISTANCE_ASSERT_SVH

// condition holds on every enabled clock edge
`define WVD_ASSERT_HOLD(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define WVD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define WVD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/wvd_pkg.sv
// Shared types, constants and helpers for the weighted vector distance block
// No dependencies; imported by wvd_datapath, weighted_vector_distance and the test bench
`timescale 1ns / 1ps

package wvd_pkg;

    // default sizes
    localparam int COORD_BITS_DEF = 16;
    localparam int ACC_BITS_DEF   = 48;

    // fixed field widths
    localparam int WEIGHT_W  = 16;
    localparam int FRAC_BITS = 8;
    localparam int DIST_W    = 48;
    localparam int MODE_W    = 2;

    // metric modes (the unused code behaves as squared L2)
    localparam logic [MODE_W-1:0] MODE_L1      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_L2_ROOT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_L2_SQ   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_L2_ROOT;

    // datapath operations issued by the sequencer
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_CAPTURE   = 3'd1,
        OP_MUL_STEP  = 3'd2,
        OP_MUL_W     = 3'd3,
        OP_ACC       = 3'd4,
        OP_ROOT_INIT = 3'd5,
        OP_ROOT_STEP = 3'd6,
        OP_CLEAR     = 3'd7
    } op_t;

    // sequencer to datapath control
    typedef struct packed {
        op_t  op;
        logic sq_path;
    } ctrl_t;

    function automatic int imax(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

endpackage

### sv/weighted_vector_distance.sv
// Weighted L1 / L2 / squared L2 distance accumulator, top level
// Depends on wvd_pkg, wvd_datapath and weighted_vector_distance_assert.svh
`timescale 1ns / 1ps
`include "weighted_vector_distance_assert.svh"

// Each request carries one component of two vectors and its Q8.8 weight. A
// single shared adder does the multiply, accumulate and root arithmetic, so a
// request occupies the block and item_ready stays low meanwhile. In L1 mode a
// request is captured, multiplied by the weight in shift-add steps and
// accumulated; in the L2 modes the difference is first squared, so squaring and
// weighting run as two shift-add multiplies. The last component then hands the
// result to the output register, in mode 1 after a square root that yields one
// result bit per cycle. A finished result sits in an output register, so new
// requests are taken while it waits. The mode is sampled when each request is
// taken; the root follows the mode of the last one.

module weighted_vector_distance
    import wvd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [MODE_W-1:0]            metric_mode,
    // component channel
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic signed [COORD_BITS-1:0] coord_a,
    input  logic signed [COORD_BITS-1:0] coord_b,
    input  logic [WEIGHT_W-1:0]          weight,
    input  logic                         last_component,
    // result channel
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [DIST_W-1:0]            distance,
    output logic                         saturated
);

    localparam int ROOT_W  = (ACC_BITS + 1) / 2;
    localparam int CNT_MAX = imax(imax(COORD_BITS, WEIGHT_W), ROOT_W);
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int EXT_W   = imax(ACC_BITS, DIST_W);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQ    = 8'b0000_0010,
        S_WLOAD = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_RINIT = 8'b0010_0000,
        S_ROOT  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MODE_W-1:0]   mode_cfg_reg, mode_cfg_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                last_reg, last_next;
    logic                result_valid_reg, result_valid_next;
    logic [DIST_W-1:0]   distance_reg, distance_next;
    logic                saturated_reg, saturated_next;
    ctrl_t               ctrl;
    logic [ACC_BITS-1:0] acc_sum;
    logic                acc_ovf;
    logic [ROOT_W-1:0]   root;
    logic [EXT_W-1:0]    dist_sel;

    wvd_datapath #(
        .COORD_BITS (COORD_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .coord_a (coord_a),
        .coord_b (coord_b),
        .weight  (weight),
        .acc_sum (acc_sum),
        .acc_ovf (acc_ovf),
        .root    (root)
    );

    // configuration register, takes a write on any cycle
    assign cfg_ready     = 1'b1;
    assign mode_cfg_next = (cfg_valid && cfg_ready) ? metric_mode : mode_cfg_reg;

    // result value: root in mode 1, otherwise the sum
    always_comb
    begin
        dist_sel = '0;
        if (mode_reg == MODE_L2_ROOT)
        begin
            dist_sel[ROOT_W-1:0] = root;
        end
        else
        begin
            dist_sel[ACC_BITS-1:0] = acc_sum;
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        mode_next         = mode_reg;
        last_next         = last_reg;
        distance_next     = distance_reg;
        saturated_next    = saturated_reg;
        result_valid_next = result_valid_reg && !result_ready;
        ctrl.op           = OP_NONE;
        ctrl.sq_path      = (mode_cfg_reg != MODE_L1);
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl.op    = OP_CAPTURE;
                    mode_next  = mode_cfg_reg;
                    last_next  = last_component;
                    cnt_next   = '0;
                    state_next = ctrl.sq_path ? S_SQ : S_MUL;
                end
            end
            S_SQ:
            begin
                ctrl.op  = OP_MUL_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COORD_BITS - 1))
                begin
                    state_next = S_WLOAD;
                end
            end
            S_WLOAD:
            begin
                ctrl.op    = OP_MUL_W;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ctrl.op  = OP_MUL_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WEIGHT_W - 1))
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                ctrl.op = OP_ACC;
                priority if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (mode_reg == MODE_L2_ROOT)
                begin
                    state_next = S_RINIT;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_RINIT:
            begin
                ctrl.op    = OP_ROOT_INIT;
                cnt_next   = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                ctrl.op  = OP_ROOT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    ctrl.op           = OP_CLEAR;
                    result_valid_next = 1'b1;
                    distance_next     = dist_sel[DIST_W-1:0];
                    saturated_next    = acc_ovf;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            mode_cfg_reg     <= MODE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            mode_cfg_reg     <= mode_cfg_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // per-request payload
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        last_reg      <= last_next;
        distance_reg  <= distance_next;
        saturated_reg <= saturated_next;
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign distance     = distance_reg;
    assign saturated    = saturated_reg;

    // handing off a result leaves a cleared accumulator behind
    `WVD_ASSERT_NXT(a_emit_clears, clk, rst_n, (state_reg == S_EMIT) && (state_next == S_IDLE), (acc_sum == '0) && !acc_ovf, "accumulator not cleared after result")
    // the root is only taken for a vector ending in mode 1
    `WVD_ASSERT_IMP(a_root_mode, clk, rst_n, (state_reg == S_ROOT) || (state_reg == S_RINIT), last_reg && (mode_reg == MODE_L2_ROOT), "root taken outside mode 1")
    // the weight multiply never runs past its bit count
    `WVD_ASSERT_IMP(a_mul_count, clk, rst_n, state_reg == S_MUL, cnt_reg < CNT_W'(WEIGHT_W), "weight multiply step count overrun")

endmodule

### sv/wvd_datapath.sv
// Datapath of the weighted vector distance block: one shared adder used for
// shift-add multiply, saturating accumulate and digit-by-digit square root
// Depends on wvd_pkg and weighted_vector_distance_assert.svh
`timescale 1ns / 1ps
`include "weighted_vector_distance_assert.svh"

module wvd_datapath
    import wvd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctrl_t                        ctrl,
    input  logic signed [COORD_BITS-1:0] coord_a,
    input  logic signed [COORD_BITS-1:0] coord_b,
    input  logic [WEIGHT_W-1:0]          weight,
    output logic [ACC_BITS-1:0]          acc_sum,
    output logic                         acc_ovf,
    output logic [(ACC_BITS+1)/2-1:0]    root
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int PROD_W = SQ_W + WEIGHT_W;
    localparam int MPL_W  = imax(COORD_BITS, WEIGHT_W);
    localparam int ROOT_W = (ACC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int ALU_W  = imax(imax(PROD_W, ACC_BITS), REM_W) + 1;
    localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

    logic [PROD_W-1:0]   mcand_reg;
    logic [MPL_W-1:0]    mplier_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [ACC_BITS-1:0] sum_reg, sum_next;
    logic                ovf_reg, ovf_next;
    logic [ROOT_W-1:0]   root_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [RAD_W-1:0]    rad_reg;

    logic signed [DIFF_W-1:0] diff;
    logic [COORD_BITS-1:0]    mag;
    logic [REM_W-1:0]         rem_shift;
    logic [ALU_W-1:0]         alu_a, alu_b;
    logic                     alu_sub;
    logic [ALU_W:0]           alu_res;
    logic                     acc_clip;

    // magnitude of the component difference
    always_comb
    begin
        diff = DIFF_W'(coord_a) - DIFF_W'(coord_b);
        mag  = diff[DIFF_W-1] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
    end

    // next partial remainder of the square root
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};

    // shared adder operand select
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (ctrl.op)
            OP_MUL_STEP:
            begin
                alu_a[PROD_W-1:0] = prod_reg;
                alu_b[PROD_W-1:0] = mcand_reg;
            end
            OP_ACC:
            begin
                alu_a[ACC_BITS-1:0]         = sum_reg;
                alu_b[PROD_W-FRAC_BITS-1:0] = prod_reg[PROD_W-1:FRAC_BITS];
            end
            OP_ROOT_STEP:
            begin
                alu_a[REM_W-1:0] = rem_shift;
                alu_b[REM_W-1:0] = {root_reg, 2'b01};
                alu_sub          = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // shared adder, carry out means no borrow when subtracting
    assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + {{ALU_W{1'b0}}, alu_sub};

    // clip when the sum spills past the accumulator width
    assign acc_clip = |alu_res[ALU_W:ACC_BITS];

    // accumulator and clip flag
    always_comb
    begin
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (ctrl.op == OP_ACC)
        begin
            sum_next = acc_clip ? ACC_MAX : alu_res[ACC_BITS-1:0];
            ovf_next = ovf_reg | acc_clip;
        end
        else if (ctrl.op == OP_CLEAR)
        begin
            sum_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
        end
    end

    // multiplier and square root working registers
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_CAPTURE:
            begin
                mcand_reg  <= PROD_W'(mag);
                mplier_reg <= ctrl.sq_path ? MPL_W'(mag) : MPL_W'(weight);
                prod_reg   <= '0;
                w_reg      <= weight;
            end
            OP_MUL_STEP:
            begin
                if (mplier_reg[0])
                begin
                    prod_reg <= alu_res[PROD_W-1:0];
                end
                mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[MPL_W-1:1]};
            end
            OP_MUL_W:
            begin
                mcand_reg  <= prod_reg;
                mplier_reg <= MPL_W'(w_reg);
                prod_reg   <= '0;
            end
            OP_ROOT_INIT:
            begin
                rad_reg  <= RAD_W'(sum_reg);
                root_reg <= '0;
                rem_reg  <= '0;
            end
            OP_ROOT_STEP:
            begin
                if (alu_res[ALU_W])
                begin
                    rem_reg  <= alu_res[REM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign acc_sum = sum_reg;
    assign acc_ovf = ovf_reg;
    assign root    = root_reg;

    // once clipped, the sum stays pinned until cleared
    `WVD_ASSERT_HOLD(a_clip_pins_max, clk, rst_n, !ovf_reg || (sum_reg == ACC_MAX), "clip flag set but sum below max")
    // partial products never outgrow the product register
    `WVD_ASSERT_IMP(a_prod_fits, clk, rst_n, (ctrl.op == OP_MUL_STEP) && mplier_reg[0], alu_res[ALU_W:PROD_W] == '0, "partial product overflow")

endmodule

### dv/weighted_vector_distance_test.sv
// Self-checking bench for weighted_vector_distance: streams component requests in every
// metric mode, predicts each distance and saturation flag, and compares them with the results
// Depends on wvd_pkg and the weighted_vector_distance RTL
`timescale 1ns / 1ps

module weighted_vector_distance_test
    import wvd_pkg::*;
;

    localparam int COORD_W = COORD_BITS_DEF;
    localparam int SUM_W = ACC_BITS_DEF;
    // the spare mode code behaves like squared L2
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    // largest single L2 term: full-scale difference at full weight
    localparam logic [63:0] BIG_L2_TERM = (64'd65535 * 64'd65535 * 64'd65535) >> FRAC_BITS;
    // worst case busy time: L2 request, result handoff and square root, with margin
    localparam int SETTLE_CYCLES = 80;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              saturated;
    } distance_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [MODE_W-1:0]         metric_mode;
    logic                      item_valid;
    logic                      item_ready;
    logic signed [COORD_W-1:0] coord_a;
    logic signed [COORD_W-1:0] coord_b;
    logic [WEIGHT_W-1:0]       weight;
    logic                      last_component;
    logic                      result_valid;
    logic                      result_ready;
    logic [DIST_W-1:0]         distance;
    logic                      saturated;

    // predictor state
    logic [MODE_W-1:0] metric_mode_q;
    logic [SUM_W-1:0]  dist_sum;
    logic              dist_clipped;
    distance_t         expected_distances [$];

    // bookkeeping
    bit calm = 1'b0;
    int mismatch_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int clip_count = 0;
    int vectors_by_mode [4] = '{0, 0, 0, 0};

    weighted_vector_distance dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .metric_mode    (metric_mode),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .coord_a        (coord_a),
        .coord_b        (coord_b),
        .weight         (weight),
        .last_component (last_component),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .distance       (distance),
        .saturated      (saturated)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("weighted_vector_distance_test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // floor square root, one result bit at a time
    function automatic logic [SUM_W-1:0] floor_root(input logic [SUM_W-1:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = SUM_W / 2; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= {16'd0, x})
                root = trial;
        end
        return root[SUM_W-1:0];
    endfunction

    // add one weighted term, and on the last component queue the distance
    task automatic accumulate_component(input logic signed [COORD_W-1:0] a,
                                        input logic signed [COORD_W-1:0] b,
                                        input logic [WEIGHT_W-1:0] w,
                                        input logic is_last);
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0]        mag;
        logic [95:0]             term;
        distance_t               res;
        diff = a - b;
        mag = (diff < 0) ? -diff : diff;
        if (metric_mode_q == MODE_L1)
            term = (mag * w) >> FRAC_BITS;
        else
            term = (mag * mag * w) >> FRAC_BITS;
        // saturate; landing exactly on the maximum is not a clip
        if (term > SUM_MAX - dist_sum)
        begin
            dist_sum = SUM_MAX;
            dist_clipped = 1'b1;
        end
        else
            dist_sum = dist_sum + term[SUM_W-1:0];
        if (is_last)
        begin
            res.distance = (metric_mode_q == MODE_L2_ROOT) ? floor_root(dist_sum) : dist_sum;
            res.saturated = dist_clipped;
            expected_distances.push_back(res);
            vectors_by_mode[metric_mode_q]++;
            dist_sum = '0;
            dist_clipped = 1'b0;
        end
    endtask

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 11))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'h0100;
            3: return 16'hffff;
            4: return WEIGHT_W'($urandom_range(0, 255));
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic int pick_vector_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        if (r < 95)
            return $urandom_range(7, 20);
        return $urandom_range(40, 80);
    endfunction

    // send one component request; valid stays high after acceptance until the next call
    task automatic send_component(input logic signed [COORD_W-1:0] a,
                                  input logic signed [COORD_W-1:0] b,
                                  input logic [WEIGHT_W-1:0] w,
                                  input logic is_last);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid = 1'b1;
        coord_a = a;
        coord_b = b;
        weight = w;
        last_component = is_last;
        do @(posedge clk); while (!item_ready);
        accumulate_component(a, b, w, is_last);
        items_sent++;
    endtask

    // stop sending and wait until every queued distance has come back
    task automatic wait_for_results(input int settle);
        @(negedge clk);
        item_valid = 1'b0;
        while (expected_distances.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // mode write, only once the block has gone quiet
    task automatic write_metric_mode(input logic [MODE_W-1:0] mode);
        wait_for_results(SETTLE_CYCLES);
        @(negedge clk);
        cfg_valid = 1'b1;
        metric_mode = mode;
        do @(posedge clk); while (!cfg_ready);
        metric_mode_q = mode;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // extreme coordinates and weights in every mode, starting on the reset mode
    task automatic test_corner_components();
        logic [MODE_W-1:0] modes [4];
        modes = '{MODE_L2_ROOT, MODE_L1, MODE_L2_SQ, MODE_SPARE};
        for (int i = 0; i < 4; i++)
        begin
            if (i != 0)
                write_metric_mode(modes[i]);
            send_component(16'sh7fff, 16'sh8000, 16'hffff, 1'b1);
            send_component(16'sh8000, 16'sh7fff, 16'hffff, 1'b1);
            send_component(16'sh8000, 16'sh8000, 16'hffff, 1'b0);
            // fraction of a tiny term is dropped
            send_component(16'sh0001, 16'sh0000, 16'h00ff, 1'b0);
            send_component(-16'sd5, 16'sd3, 16'h0180, 1'b1);
        end
    endtask

    // mode written between components of one vector
    task automatic test_mode_change_mid_vector();
        write_metric_mode(MODE_L1);
        send_component(16'sd100, -16'sd100, 16'h0200, 1'b0);
        write_metric_mode(MODE_L2_ROOT);
        send_component(16'sd300, 16'sd0, 16'h0100, 1'b1);
        send_component(16'sh8000, 16'sh7fff, 16'hffff, 1'b0);
        write_metric_mode(MODE_L2_SQ);
        send_component(16'sd1, -16'sd1, 16'h012c, 1'b0);
        send_component(16'sd77, 16'sd0, 16'h0100, 1'b1);
    endtask

    // bring the sum up to exactly the maximum with terms of known size (L2 modes only)
    task automatic fill_to_maximum();
        logic [SUM_W-1:0]    room;
        logic [SUM_W-1:0]    units;
        logic [WEIGHT_W-1:0] w;
        int                  level_shift [3];
        int                  level_half [3];
        // a difference of 2*half gives a term of weight << shift
        level_shift = '{22, 8, 0};
        level_half = '{16384, 128, 8};
        room = SUM_MAX - dist_sum;
        while (room >= BIG_L2_TERM)
        begin
            send_component(16'sh7fff, 16'sh8000, 16'hffff, 1'b0);
            room = SUM_MAX - dist_sum;
        end
        for (int s = 0; s < 3; s++)
        begin
            while ((room >> level_shift[s]) != 0)
            begin
                units = room >> level_shift[s];
                w = (units > 65535) ? 16'hffff : units[WEIGHT_W-1:0];
                send_component(COORD_W'(level_half[s]), COORD_W'(-level_half[s]), w, 1'b0);
                room = SUM_MAX - dist_sum;
            end
        end
    endtask

    // exact maximum is no clip; one more unit clips and the root follows
    task automatic test_sum_at_maximum();
        write_metric_mode(MODE_L2_SQ);
        fill_to_maximum();
        send_component(16'sd0, 16'sd0, 16'h0000, 1'b1);
        write_metric_mode(MODE_L2_ROOT);
        fill_to_maximum();
        send_component(16'sd8, -16'sd8, 16'h0001, 1'b1);
    endtask

    // random vectors in phases, the mode changing between phases, often mid-vector
    task automatic test_random_streams();
        logic [MODE_W-1:0] mode;
        int                vec_left;
        vec_left = 0;
        for (int phase = 0; phase < 11; phase++)
        begin
            mode = (phase < 4) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 3));
            write_metric_mode(mode);
            calm = (phase == 6);
            for (int k = 0; k < 55; k++)
            begin
                if (vec_left == 0)
                    vec_left = pick_vector_length();
                vec_left--;
                send_component(pick_coord(), pick_coord(), pick_weight(), vec_left == 0);
                // now and then hold off until all distances are back
                if (vec_left == 0 && $urandom_range(0, 19) == 0)
                    wait_for_results(0);
            end
        end
        calm = 1'b0;
        if (vec_left != 0)
            send_component(pick_coord(), pick_coord(), pick_weight(), 1'b1);
    endtask

    // result side stalls
    initial
    begin
        int stall;
        result_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            result_ready = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                result_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // compare each returned distance with the oldest prediction
    always @(posedge clk)
    begin : result_compare
        distance_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_distances.size() == 0)
                report_mismatch($sformatf("unexpected distance %0d", distance));
            else
            begin
                want = expected_distances.pop_front();
                results_checked++;
                if (want.saturated)
                    clip_count++;
                if (distance !== want.distance)
                    report_mismatch($sformatf("distance %0d, predicted %0d",
                                              distance, want.distance));
                if (saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %b, predicted %b",
                                              saturated, want.saturated));
            end
        end
    end

    // stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        metric_mode = MODE_RESET;
        item_valid = 1'b0;
        coord_a = '0;
        coord_b = '0;
        weight = '0;
        last_component = 1'b0;
        metric_mode_q = MODE_RESET;
        dist_sum = '0;
        dist_clipped = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_components();
        test_mode_change_mid_vector();
        test_sum_at_maximum();
        test_random_streams();

        wait_for_results(SETTLE_CYCLES);
        if (expected_distances.size() != 0)
            report_mismatch($sformatf("%0d distances never returned",
                                      expected_distances.size()));
        $display("sent %0d components, checked %0d distances (%0d saturated)",
                 items_sent, results_checked, clip_count);
        $display("vectors per mode: L1 %0d, L2 root %0d, squared L2 %0d, spare code %0d",
                 vectors_by_mode[0], vectors_by_mode[1], vectors_by_mode[2],
                 vectors_by_mode[3]);
        if (mismatch_count == 0)
            $display("weighted_vector_distance_test passed");
        else
            $display("weighted_vector_distance_test failed");
        $finish;
    end

endmodule

### weighted_vector_distance.f
+incdir+sv
sv/wvd_pkg.sv
sv/wvd_datapath.sv
sv/weighted_vector_distance.sv
dv/weighted_vector_distance_test.sv
